[design/tfd_pkg.sv]
// ============================================================================
// tfd_pkg - shared types and constants of the triangle fragment depth unit
// Widths of the payload, internal arithmetic widths and the pipeline layout.
// ============================================================================
package tfd_pkg;

    localparam int SCREEN_BITS = 12;

    localparam int COORD_W = 16;
    localparam int DEPTH_W = 24;
    localparam int PIX_W   = 12;
    localparam int COLOR_W = 32;

    // Internal arithmetic widths.
    localparam int DIFF_W = 18;              // coordinate differences
    localparam int PROD_W = 2 * DIFF_W;      // one edge product
    localparam int SUM_W  = PROD_W + 2;      // edge values, area, weights
    localparam int MAG_W  = 36;              // weight and area magnitudes
    localparam int HALF_W = MAG_W / 2;       // weight slice per partial product
    localparam int PP_W   = HALF_W + DEPTH_W;
    localparam int NUM_W  = 62;              // weighted depth sum and dividend
    localparam int QUO_W  = DEPTH_W + 1;     // quotient, one guard bit for clamp
    localparam int DVS_W  = MAG_W + 1;       // divisor is twice the area
    localparam int REM_W  = DVS_W + 1;

    localparam int FRONT_STAGES = 8;
    localparam int DIV_STAGES   = QUO_W;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << SCREEN_BITS) - 64'd1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert0_x;
        logic signed [COORD_W-1:0] vert0_y;
        logic        [DEPTH_W-1:0] vert0_depth;
        logic signed [COORD_W-1:0] vert1_x;
        logic signed [COORD_W-1:0] vert1_y;
        logic        [DEPTH_W-1:0] vert1_depth;
        logic signed [COORD_W-1:0] vert2_x;
        logic signed [COORD_W-1:0] vert2_y;
        logic        [DEPTH_W-1:0] vert2_depth;
        logic        [PIX_W-1:0]   pixel_x;
        logic        [PIX_W-1:0]   pixel_y;
        logic        [COLOR_W-1:0] fill_color;
    } item_t;

    typedef struct packed {
        logic               covered;
        logic [PIX_W-1:0]   frag_x;
        logic [PIX_W-1:0]   frag_y;
        logic [DEPTH_W-1:0] frag_depth;
        logic [COLOR_W-1:0] frag_color;
    } frag_t;

    // Fields that ride along the pipeline beside the arithmetic.
    typedef struct packed {
        logic               covered;
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] color;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [NUM_W-1:0] dvd;
        logic [DVS_W-1:0] dvs;
    } front_t;

    typedef struct packed {
        side_t            side;
        logic [QUO_W-1:0] quo;
    } quot_t;

    function automatic logic signed [DIFF_W-1:0] sext_coord(
        input logic signed [COORD_W-1:0] v
    );
        return {{(DIFF_W - COORD_W){v[COORD_W-1]}}, v};
    endfunction

endpackage

[design/triangle_fragment_depth.sv]
// ============================================================================
// triangle_fragment_depth - per-pixel coverage and depth of one triangle
// Edge-function test of a pixel center and barycentric depth interpolation.
// ============================================================================
// Usage: an item carries three Q12.4 vertices with Q8.16 depths, a pixel
// position and a flat color. Each accepted item yields exactly one fragment
// on the output channel, in order, telling whether the pixel center lies in a
// non-degenerate triangle and giving its rounded, saturated depth (zero when
// the pixel is not covered). Both channels are valid/ready; a transfer takes
// place on a clock edge with valid and ready both high.
// The pipeline has 34 register stages: eight stages of edge and weight
// arithmetic, 25 divider stages that each produce one quotient bit, and one
// output register. Throughput is one item per cycle while the receiver
// keeps frag_ready high.
// Reset clears every stage's valid bit; the data registers are not reset.
// When the receiver stalls, full stages move on into any empty stage after
// them, so input transfers keep being taken until every stage is full.
// ============================================================================
module triangle_fragment_depth (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  tfd_pkg::item_t  item,
    output logic            frag_valid,
    input  logic            frag_ready,
    output tfd_pkg::frag_t  frag
);
    import tfd_pkg::*;

    // One valid bit per pipeline stage, and the advance enables derived from
    // them: a stage loads when it is empty or when the stage after it moves.
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] en;

    front_t front;
    quot_t  quot;
    frag_t  frag_reg;
    frag_t  frag_next;

    always_comb
    begin
        en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || frag_ready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < PIPE_STAGES; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = (i == 0) ? item_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    tfd_front u_front (
        .clk    (clk),
        .en     (en[FRONT_STAGES-1:0]),
        .item   (item),
        .result (front)
    );

    tfd_div u_div (
        .clk     (clk),
        .en      (en[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
        .operand (front),
        .result  (quot)
    );

    // Output stage: clamp the rounded quotient and zero it for uncovered
    // pixels. For a covered pixel the quotient never exceeds one past the depth
    // range, so its top bit alone signals saturation.
    always_comb
    begin
        frag_next.covered    = quot.side.covered;
        frag_next.frag_x     = quot.side.x;
        frag_next.frag_y     = quot.side.y;
        frag_next.frag_color = quot.side.color;
        if (!quot.side.covered)
        begin
            frag_next.frag_depth = '0;
        end
        else if (quot.quo[QUO_W-1])
        begin
            frag_next.frag_depth = DEPTH_MAX;
        end
        else
        begin
            frag_next.frag_depth = quot.quo[DEPTH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[PIPE_STAGES-1])
        begin
            frag_reg <= frag_next;
        end
    end

    assign item_ready = en[0];
    assign frag_valid = valid_reg[PIPE_STAGES-1];
    assign frag       = frag_reg;

`ifndef NO_ASSERTIONS
    // An uncovered fragment always carries zero depth.
    a_uncovered_depth: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && !frag.covered |-> frag.frag_depth == '0)
        else $error("uncovered fragment with nonzero depth");

    // With the output register empty, the whole pipeline can advance.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !frag_valid |-> item_ready)
        else $error("input stalled while output stage is empty");

    // A zero divisor means a degenerate triangle, which is never covered.
    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[FRONT_STAGES-1] |-> !(front.side.covered && front.dvs == '0))
        else $error("degenerate triangle marked covered");
`endif

endmodule

[design/tfd_front.sv]
// ============================================================================
// tfd_front - edge functions, coverage and weighted depth sum
// Eight register stages from the vertices to the dividend and divisor.
// ============================================================================
module tfd_front (
    input  logic                                  clk,
    input  logic [tfd_pkg::FRONT_STAGES-1:0]      en,
    input  tfd_pkg::item_t                        item,
    output tfd_pkg::front_t                       result
);
    import tfd_pkg::*;

    // Stage 0: differences.
    logic signed [DIFF_W-1:0] bax_reg, bay_reg, pax_reg, pay_reg;
    logic signed [DIFF_W-1:0] cbx_reg, cby_reg, pbx_reg, pby_reg;
    logic signed [DIFF_W-1:0] acx_reg, acy_reg, pcx_reg, pcy_reg;
    logic [DEPTH_W-1:0] z0_reg [3];
    side_t              side0_reg;

    // Stage 1: products.
    logic signed [PROD_W-1:0] e0a_reg, e0b_reg, e1a_reg, e1b_reg, e2a_reg, e2b_reg;
    logic signed [PROD_W-1:0] ara_reg, arb_reg, waa_reg, wab_reg;
    logic [DEPTH_W-1:0] z1_reg [3];
    side_t              side1_reg;

    // Stage 2: edge values, area and weights.
    logic signed [SUM_W-1:0] e0_reg, e1_reg, e2_reg, area_reg, wa_reg;
    logic [DEPTH_W-1:0] z2_reg [3];
    side_t              side2_reg;

    // Stage 3: coverage and magnitudes.
    logic [MAG_W-1:0]   w3_reg [3];
    logic [MAG_W-1:0]   amag3_reg;
    logic [DEPTH_W-1:0] z3_reg [3];
    side_t              side3_reg;
    side_t              side3_next;

    // Stage 4: partial products.
    logic [PP_W-1:0]  lo4_reg [3];
    logic [PP_W-1:0]  hi4_reg [3];
    logic [MAG_W-1:0] amag4_reg;
    side_t            side4_reg;

    // Stage 5: per-vertex products.
    logic [NUM_W-1:0] p5_reg [3];
    logic [MAG_W-1:0] amag5_reg;
    side_t            side5_reg;

    // Stage 6: weighted sum.
    logic [NUM_W-1:0] num6_reg;
    logic [MAG_W-1:0] amag6_reg;
    side_t            side6_reg;

    // Stage 7: dividend and divisor.
    logic [NUM_W-1:0] dvd7_reg;
    logic [DVS_W-1:0] dvs7_reg;
    side_t            side7_reg;

    logic [PIX_W-1:0]         mx, my;
    logic signed [DIFF_W-1:0] ax, ay, bx, by, cx, cy, px, py;
    logic signed [SUM_W-1:0]  wc2;
    logic                     inside2, neg2;

    always_comb
    begin
        mx = item.pixel_x & PIX_MASK;
        my = item.pixel_y & PIX_MASK;
        px = $signed({2'b00, mx, 4'b1000});
        py = $signed({2'b00, my, 4'b1000});
        ax = sext_coord(item.vert0_x);
        ay = sext_coord(item.vert0_y);
        bx = sext_coord(item.vert1_x);
        by = sext_coord(item.vert1_y);
        cx = sext_coord(item.vert2_x);
        cy = sext_coord(item.vert2_y);
    end

    always_comb
    begin
        inside2 = (!e0_reg[SUM_W-1] && !e1_reg[SUM_W-1] && !e2_reg[SUM_W-1]) ||
                  ((e0_reg[SUM_W-1] || e0_reg == '0) &&
                   (e1_reg[SUM_W-1] || e1_reg == '0) &&
                   (e2_reg[SUM_W-1] || e2_reg == '0));
        neg2 = area_reg[SUM_W-1];
        // The third weight closes the sum to the doubled area.
        wc2 = area_reg - wa_reg - e2_reg;
        side3_next         = side2_reg;
        side3_next.covered = inside2 && (area_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            bax_reg <= bx - ax;  bay_reg <= by - ay;
            pax_reg <= px - ax;  pay_reg <= py - ay;
            cbx_reg <= cx - bx;  cby_reg <= cy - by;
            pbx_reg <= px - bx;  pby_reg <= py - by;
            acx_reg <= ax - cx;  acy_reg <= ay - cy;
            pcx_reg <= px - cx;  pcy_reg <= py - cy;
            z0_reg[0] <= item.vert0_depth;
            z0_reg[1] <= item.vert1_depth;
            z0_reg[2] <= item.vert2_depth;
            side0_reg <= '{covered: 1'b0, x: mx, y: my, color: item.fill_color};
        end
        if (en[1])
        begin
            e0a_reg <= bax_reg * pay_reg;  e0b_reg <= bay_reg * pax_reg;
            e1a_reg <= cbx_reg * pby_reg;  e1b_reg <= cby_reg * pbx_reg;
            e2a_reg <= acx_reg * pcy_reg;  e2b_reg <= acy_reg * pcx_reg;
            ara_reg <= cby_reg * acx_reg;  arb_reg <= cbx_reg * acy_reg;
            waa_reg <= cby_reg * pcx_reg;  wab_reg <= cbx_reg * pcy_reg;
            z1_reg    <= z0_reg;
            side1_reg <= side0_reg;
        end
        if (en[2])
        begin
            e0_reg   <= SUM_W'(e0a_reg) - SUM_W'(e0b_reg);
            e1_reg   <= SUM_W'(e1a_reg) - SUM_W'(e1b_reg);
            e2_reg   <= SUM_W'(e2a_reg) - SUM_W'(e2b_reg);
            area_reg <= SUM_W'(arb_reg) - SUM_W'(ara_reg);
            wa_reg   <= SUM_W'(wab_reg) - SUM_W'(waa_reg);
            z2_reg    <= z1_reg;
            side2_reg <= side1_reg;
        end
        if (en[3])
        begin
            // The weight of vertex 1 equals the edge value e2.
            w3_reg[0] <= neg2 ? MAG_W'(-wa_reg) : MAG_W'(wa_reg);
            w3_reg[1] <= neg2 ? MAG_W'(-e2_reg) : MAG_W'(e2_reg);
            w3_reg[2] <= neg2 ? MAG_W'(-wc2) : MAG_W'(wc2);
            amag3_reg <= neg2 ? MAG_W'(-area_reg) : MAG_W'(area_reg);
            z3_reg    <= z2_reg;
            side3_reg <= side3_next;
        end
        if (en[4])
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo4_reg[k] <= PP_W'(w3_reg[k][HALF_W-1:0]) * PP_W'(z3_reg[k]);
                hi4_reg[k] <= PP_W'(w3_reg[k][MAG_W-1:HALF_W]) * PP_W'(z3_reg[k]);
            end
            amag4_reg <= amag3_reg;
            side4_reg <= side3_reg;
        end
        if (en[5])
        begin
            for (int k = 0; k < 3; k++)
            begin
                p5_reg[k] <= NUM_W'({hi4_reg[k], {HALF_W{1'b0}}}) + NUM_W'(lo4_reg[k]);
            end
            amag5_reg <= amag4_reg;
            side5_reg <= side4_reg;
        end
        if (en[6])
        begin
            num6_reg  <= p5_reg[0] + p5_reg[1] + p5_reg[2];
            amag6_reg <= amag5_reg;
            side6_reg <= side5_reg;
        end
        if (en[7])
        begin
            // Rounding to nearest: (2 * num + area) / (2 * area).
            dvd7_reg  <= {num6_reg[NUM_W-2:0], 1'b0} + NUM_W'(amag6_reg);
            dvs7_reg  <= {amag6_reg, 1'b0};
            side7_reg <= side6_reg;
        end
    end

    assign result = '{side: side7_reg, dvd: dvd7_reg, dvs: dvs7_reg};

endmodule

[design/tfd_div.sv]
// ============================================================================
// tfd_div - pipelined restoring divider
// One quotient bit per register stage, most significant bit first.
// ============================================================================
module tfd_div (
    input  logic                               clk,
    input  logic [tfd_pkg::DIV_STAGES-1:0]     en,
    input  tfd_pkg::front_t                    operand,
    output tfd_pkg::quot_t                     result
);
    import tfd_pkg::*;

    logic [REM_W-1:0] rem_reg  [DIV_STAGES];
    logic [QUO_W-1:0] low_reg  [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES];
    logic [DVS_W-1:0] dvs_reg  [DIV_STAGES];
    side_t            side_reg [DIV_STAGES];

    logic [REM_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0] low_next [DIV_STAGES];
    logic [QUO_W-1:0] quo_next [DIV_STAGES];

    always_comb
    begin
        logic [REM_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] quo_in;
        logic [DVS_W-1:0] dvs_in;
        logic [REM_W-1:0] trial;
        logic             ge;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem_in = REM_W'(operand.dvd[NUM_W-1:QUO_W]);
                low_in = operand.dvd[QUO_W-1:0];
                quo_in = '0;
                dvs_in = operand.dvs;
            end
            else
            begin
                rem_in = rem_reg[s-1];
                low_in = low_reg[s-1];
                quo_in = quo_reg[s-1];
                dvs_in = dvs_reg[s-1];
            end
            trial       = {rem_in[REM_W-2:0], low_in[QUO_W-1]};
            ge          = trial >= REM_W'(dvs_in);
            rem_next[s] = ge ? trial - REM_W'(dvs_in) : trial;
            low_next[s] = {low_in[QUO_W-2:0], 1'b0};
            quo_next[s] = {quo_in[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (en[s])
            begin
                rem_reg[s]  <= rem_next[s];
                low_reg[s]  <= low_next[s];
                quo_reg[s]  <= quo_next[s];
                dvs_reg[s]  <= (s == 0) ? operand.dvs : dvs_reg[(s == 0) ? 0 : s - 1];
                side_reg[s] <= (s == 0) ? operand.side : side_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign result = '{side: side_reg[DIV_STAGES-1], quo: quo_reg[DIV_STAGES-1]};

endmodule
